### rtl/core/ipv6ts_pkg.sv
package ipv6ts_pkg;

    localparam int NUM_PIECES = 8;
    localparam logic [3:0] NO_RUN = 4'd8;

    localparam logic [6:0] CHR_COLON = 7'h3a;
    localparam logic [6:0] CHR_OPEN  = 7'h5b;
    localparam logic [6:0] CHR_CLOSE = 7'h5d;
    localparam logic [6:0] CHR_ZERO  = 7'h30;
    localparam logic [6:0] CHR_ALPHA = 7'h57;

    typedef struct packed {
        logic       zero;
        logic [1:0] lead;
    } lane_info_t;

    typedef struct packed {
        logic [3:0] start;
        logic [3:0] stop;
    } run_info_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] code;
        if (nib < 4'd10)
        begin
            code = CHR_ZERO + {3'b000, nib};
        end
        else
        begin
            code = CHR_ALPHA + {3'b000, nib};
        end
        return code;
    endfunction

endpackage

### rtl/core/ipv6ts_lane.sv
module ipv6ts_lane (
    input  logic [15:0]            piece,
    output ipv6ts_pkg::lane_info_t info
);

    always_comb
    begin
        info.zero = (piece == 16'd0);
        if (piece[15:12] != 4'd0)
        begin
            info.lead = 2'd0;
        end
        else if (piece[11:8] != 4'd0)
        begin
            info.lead = 2'd1;
        end
        else if (piece[7:4] != 4'd0)
        begin
            info.lead = 2'd2;
        end
        else
        begin
            info.lead = 2'd3;
        end
    end

endmodule

### rtl/core/ipv6ts_merge.sv
module ipv6ts_merge (
    input  logic [7:0]            zero_mask,
    output ipv6ts_pkg::run_info_t run
);

    logic [3:0] run_len [8];

    // zero run length starting at each piece
    always_comb
    begin
        logic alive;
        for (int i = 0; i < ipv6ts_pkg::NUM_PIECES; i++)
        begin
            run_len[i] = 4'd0;
            alive = 1'b1;
            for (int j = 0; j < ipv6ts_pkg::NUM_PIECES; j++)
            begin
                if (j >= i)
                begin
                    if (alive && zero_mask[j])
                    begin
                        run_len[i] = run_len[i] + 4'd1;
                    end
                    else
                    begin
                        alive = 1'b0;
                    end
                end
            end
        end
    end

    // first longest run of two or more
    always_comb
    begin
        logic [3:0] best_len;
        best_len = 4'd1;
        run.start = ipv6ts_pkg::NO_RUN;
        run.stop = ipv6ts_pkg::NO_RUN;
        for (int i = 0; i < ipv6ts_pkg::NUM_PIECES; i++)
        begin
            if (run_len[i] > best_len)
            begin
                best_len = run_len[i];
                run.start = 4'(i);
                run.stop = 4'(i) + run_len[i];
            end
        end
    end

endmodule

### rtl/core/ipv6_text_serializer.sv
// ipv6_text_serializer
// input channel: one word per IPv6 address, eight 16-bit pieces, piece_0 most
//   significant, handshake in_valid/in_ready
// output channel: one ASCII character per word on char_code, last_char high on
//   the final character of an address, handshake out_valid/out_ready
// config: cfg_wr_en writes cfg_wr_data into bracket_enable at once; write only
//   while no address is in flight
// text is the canonical form: lowercase hex, no leading zeros, first longest
//   run of two or more zero pieces shown as "::", optional square brackets
// eight lanes classify the pieces in parallel, a merge stage picks the zero
//   run, then a sequencer emits one character per cycle
// latency: the first character reaches the output register two cycles after
//   the address is taken, three when brackets are off
// throughput: one address per (characters + 2) cycles with brackets, + 3
//   without, 5 to 43 cycles; the sequencer handles one address at a time and
//   in_ready is high only while it is idle
// a receiver stall freezes the sequencer with the waiting character held in
//   the output register; nothing is dropped
// reset: output empty, sequencer idle, bracket_enable set to 1
module ipv6_text_serializer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] piece_0,
    input  logic [15:0] piece_1,
    input  logic [15:0] piece_2,
    input  logic [15:0] piece_3,
    input  logic [15:0] piece_4,
    input  logic [15:0] piece_5,
    input  logic [15:0] piece_6,
    input  logic [15:0] piece_7,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  char_code,
    output logic        last_char,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_OPEN,
        S_PIECE,
        S_COMPRESS2,
        S_COLON,
        S_CLOSE
    } state_t;

    state_t                 state_reg;
    logic                   bracket_reg;
    logic [15:0]            pieces_reg [8];
    ipv6ts_pkg::lane_info_t lanes_reg  [8];
    ipv6ts_pkg::run_info_t  run_reg;
    logic [3:0]             emit_piece_reg;
    logic [1:0]             emit_digit_reg;
    logic                   out_valid_reg;
    logic [6:0]             char_code_reg;
    logic                   last_char_reg;

    logic [15:0]            piece_in   [8];
    ipv6ts_pkg::lane_info_t lane_info  [8];
    logic [7:0]             zero_mask;
    ipv6ts_pkg::run_info_t  run_next;
    logic                   adv;
    logic                   load_char;
    logic [2:0]             pidx;
    logic [15:0]            cur_piece;
    logic [3:0]             cur_nib;
    logic                   at_compress;
    logic                   stop_at_end;
    logic [2:0]             pidx_inc;

    assign piece_in[0] = piece_0;
    assign piece_in[1] = piece_1;
    assign piece_in[2] = piece_2;
    assign piece_in[3] = piece_3;
    assign piece_in[4] = piece_4;
    assign piece_in[5] = piece_5;
    assign piece_in[6] = piece_6;
    assign piece_in[7] = piece_7;

    genvar g;
    generate
        for (g = 0; g < ipv6ts_pkg::NUM_PIECES; g++)
        begin : g_lane
            ipv6ts_lane u_lane (
                .piece (piece_in[g]),
                .info  (lane_info[g])
            );
            assign zero_mask[g] = lanes_reg[g].zero;
        end
    endgenerate

    ipv6ts_merge u_merge (
        .zero_mask (zero_mask),
        .run       (run_next)
    );

    assign adv         = !out_valid_reg || out_ready;
    assign load_char   = adv && (((state_reg == S_OPEN) && bracket_reg)
                         || (state_reg inside {S_PIECE, S_COMPRESS2, S_COLON, S_CLOSE}));
    assign pidx        = emit_piece_reg[2:0];
    assign pidx_inc    = pidx + 3'd1;
    assign cur_piece   = pieces_reg[pidx];
    assign cur_nib     = cur_piece[{~emit_digit_reg, 2'b00} +: 4];
    assign at_compress = (emit_piece_reg == run_reg.start);
    assign stop_at_end = (run_reg.stop == ipv6ts_pkg::NO_RUN);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign char_code = char_code_reg;
    assign last_char = last_char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bracket_reg    <= 1'b1;
            run_reg        <= '{start: ipv6ts_pkg::NO_RUN, stop: ipv6ts_pkg::NO_RUN};
            emit_piece_reg <= 4'd0;
            emit_digit_reg <= 2'd0;
            out_valid_reg  <= 1'b0;
            char_code_reg  <= 7'd0;
            last_char_reg  <= 1'b0;
            for (int i = 0; i < ipv6ts_pkg::NUM_PIECES; i++)
            begin
                pieces_reg[i] <= 16'd0;
                lanes_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bracket_reg <= cfg_wr_data;
            end
            if (load_char)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        for (int i = 0; i < ipv6ts_pkg::NUM_PIECES; i++)
                        begin
                            pieces_reg[i] <= piece_in[i];
                            lanes_reg[i]  <= lane_info[i];
                        end
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    run_reg   <= run_next;
                    state_reg <= S_OPEN;
                end
                S_OPEN:
                begin
                    emit_piece_reg <= 4'd0;
                    emit_digit_reg <= lanes_reg[0].lead;
                    if (!bracket_reg)
                    begin
                        state_reg <= S_PIECE;
                    end
                    else if (adv)
                    begin
                        char_code_reg <= ipv6ts_pkg::CHR_OPEN;
                        last_char_reg <= 1'b0;
                        state_reg     <= S_PIECE;
                    end
                end
                S_PIECE:
                begin
                    if (adv)
                    begin
                        if (at_compress)
                        begin
                            char_code_reg <= ipv6ts_pkg::CHR_COLON;
                            last_char_reg <= !bracket_reg && stop_at_end
                                             && (emit_piece_reg != 4'd0);
                            if (emit_piece_reg == 4'd0)
                            begin
                                state_reg <= S_COMPRESS2;
                            end
                            else
                            begin
                                emit_piece_reg <= run_reg.stop;
                                emit_digit_reg <= lanes_reg[run_reg.stop[2:0]].lead;
                                if (!stop_at_end)
                                begin
                                    state_reg <= S_PIECE;
                                end
                                else if (bracket_reg)
                                begin
                                    state_reg <= S_CLOSE;
                                end
                                else
                                begin
                                    state_reg <= S_IDLE;
                                end
                            end
                        end
                        else
                        begin
                            char_code_reg <= ipv6ts_pkg::hex_char(cur_nib);
                            last_char_reg <= !bracket_reg && (pidx == 3'd7)
                                             && (emit_digit_reg == 2'd3);
                            if (emit_digit_reg != 2'd3)
                            begin
                                emit_digit_reg <= emit_digit_reg + 2'd1;
                            end
                            else if (pidx != 3'd7)
                            begin
                                state_reg <= S_COLON;
                            end
                            else
                            begin
                                emit_piece_reg <= ipv6ts_pkg::NO_RUN;
                                state_reg <= bracket_reg ? S_CLOSE : S_IDLE;
                            end
                        end
                    end
                end
                S_COMPRESS2:
                begin
                    if (adv)
                    begin
                        char_code_reg  <= ipv6ts_pkg::CHR_COLON;
                        last_char_reg  <= !bracket_reg && stop_at_end;
                        emit_piece_reg <= run_reg.stop;
                        emit_digit_reg <= lanes_reg[run_reg.stop[2:0]].lead;
                        if (!stop_at_end)
                        begin
                            state_reg <= S_PIECE;
                        end
                        else if (bracket_reg)
                        begin
                            state_reg <= S_CLOSE;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_COLON:
                begin
                    if (adv)
                    begin
                        char_code_reg  <= ipv6ts_pkg::CHR_COLON;
                        last_char_reg  <= 1'b0;
                        emit_piece_reg <= emit_piece_reg + 4'd1;
                        emit_digit_reg <= lanes_reg[pidx_inc].lead;
                        state_reg      <= S_PIECE;
                    end
                end
                S_CLOSE:
                begin
                    if (adv)
                    begin
                        char_code_reg <= ipv6ts_pkg::CHR_CLOSE;
                        last_char_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/ipv6ts_checker.sv
module ipv6ts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] char_code,
    input logic       last_char
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_char))
        else $error("output word changed under stall");

    // only hex digits, colon or brackets
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((char_code >= ipv6ts_pkg::CHR_ZERO
                        && char_code <= ipv6ts_pkg::CHR_ZERO + 7'd9)
                    || (char_code >= ipv6ts_pkg::CHR_ALPHA + 7'd10
                        && char_code <= ipv6ts_pkg::CHR_ALPHA + 7'd15)
                    || char_code == ipv6ts_pkg::CHR_COLON
                    || char_code == ipv6ts_pkg::CHR_OPEN
                    || char_code == ipv6ts_pkg::CHR_CLOSE))
        else $error("illegal character code");

    // one address at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // closing bracket ends the text
    a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_code == ipv6ts_pkg::CHR_CLOSE |-> last_char)
        else $error("closing bracket not marked last");

    // opening bracket never ends the text
    a_open_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_code == ipv6ts_pkg::CHR_OPEN |-> !last_char)
        else $error("opening bracket marked last");

endmodule

bind ipv6_text_serializer ipv6ts_checker u_ipv6ts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last_char (last_char)
);

### test/ipv6_text_serializer_test.sv
module ipv6_text_serializer_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [0:7][15:0] address_t;

    typedef struct {
        logic [6:0] code;
        logic       last;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] piece_0 = '0;
    logic [15:0] piece_1 = '0;
    logic [15:0] piece_2 = '0;
    logic [15:0] piece_3 = '0;
    logic [15:0] piece_4 = '0;
    logic [15:0] piece_5 = '0;
    logic [15:0] piece_6 = '0;
    logic [15:0] piece_7 = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [6:0]  char_code;
    logic        last_char;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;

    text_char_t pending_text[$];
    text_char_t head_char;
    logic       bracket_on = 1'b1;
    logic       steady_flow = 1'b0;
    int         hold_cycles = 0;
    int         mismatches = 0;

    ipv6_text_serializer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .piece_0     (piece_0),
        .piece_1     (piece_1),
        .piece_2     (piece_2),
        .piece_3     (piece_3),
        .piece_4     (piece_4),
        .piece_5     (piece_5),
        .piece_6     (piece_6),
        .piece_7     (piece_7),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_code   (char_code),
        .last_char   (last_char),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 clk = ~clk;

    // canonical text of one address, queued as expected words
    task automatic predict_text(input address_t addr);
        int         best_at;
        int         best_len;
        int         run_at;
        int         run_len;
        int         k;
        int         d;
        logic       skipping;
        logic       started;
        logic [3:0] nib;
        logic [6:0] txt[$];
        text_char_t ch;
        best_at = int'(ipv6ts_pkg::NO_RUN);
        best_len = 1;
        run_at = int'(ipv6ts_pkg::NO_RUN);
        run_len = 0;
        for (k = 0; k < ipv6ts_pkg::NUM_PIECES; k++)
        begin
            if (addr[k] != 16'h0000)
            begin
                if (run_len > best_len)
                begin
                    best_at = run_at;
                    best_len = run_len;
                end
                run_len = 0;
            end
            else
            begin
                if (run_len == 0)
                    run_at = k;
                run_len++;
            end
        end
        if (run_len > best_len)
            best_at = run_at;

        if (bracket_on)
            txt.push_back(ipv6ts_pkg::CHR_OPEN);
        skipping = 1'b0;
        for (k = 0; k < ipv6ts_pkg::NUM_PIECES; k++)
        begin
            if (skipping && addr[k] == 16'h0000)
                continue;
            skipping = 1'b0;
            if (k == best_at)
            begin
                if (k == 0)
                    txt.push_back(ipv6ts_pkg::CHR_COLON);
                txt.push_back(ipv6ts_pkg::CHR_COLON);
                skipping = 1'b1;
                continue;
            end
            started = 1'b0;
            for (d = 3; d >= 0; d--)
            begin
                nib = addr[k][d * 4 +: 4];
                if (nib != 4'h0 || started || d == 0)
                begin
                    started = 1'b1;
                    // lowercase hex digit
                    if (nib < 4'd10)
                        txt.push_back(ipv6ts_pkg::CHR_ZERO + 7'(nib));
                    else
                        txt.push_back(ipv6ts_pkg::CHR_ALPHA + 7'(nib));
                end
            end
            if (k != ipv6ts_pkg::NUM_PIECES - 1)
                txt.push_back(ipv6ts_pkg::CHR_COLON);
        end
        if (bracket_on)
            txt.push_back(ipv6ts_pkg::CHR_CLOSE);

        foreach (txt[i])
        begin
            ch.code = txt[i];
            ch.last = (i == txt.size() - 1);
            pending_text.push_back(ch);
        end
    endtask

    // all tasks start and end at a rising edge
    task automatic send_address(input address_t addr);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        piece_0 <= addr[0];
        piece_1 <= addr[1];
        piece_2 <= addr[2];
        piece_3 <= addr[3];
        piece_4 <= addr[4];
        piece_5 <= addr[5];
        piece_6 <= addr[6];
        piece_7 <= addr[7];
        do @(posedge clk); while (!in_ready);
        predict_text(addr);
    endtask

    task automatic wait_text_done();
        in_valid <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bracket(input logic value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        bracket_on = value;
    endtask

    function automatic address_t random_address();
        address_t addr;
        int       style;
        int       k;
        int       width;
        style = $urandom_range(0, 3);
        for (k = 0; k < ipv6ts_pkg::NUM_PIECES; k++)
        begin
            if (style == 0)
                addr[k] = 16'($urandom_range(0, 65535));
            else if ($urandom_range(0, 9) < 4)
                addr[k] = 16'h0000;
            else
            begin
                width = $urandom_range(1, 4);
                addr[k] = 16'($urandom_range(0, 65535) >> (16 - 4 * width));
            end
        end
        return addr;
    endfunction

    // bracket setting from reset
    task automatic test_directed_bracketed();
        send_address({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
        send_address({16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      16'hffff, 16'hffff, 16'hffff, 16'hffff});
        send_address({16'h1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
        send_address({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1});
        send_address({16'h1, 16'h0, 16'h2, 16'h0, 16'h3, 16'h0, 16'h4, 16'h0});
        send_address({16'h1, 16'h0, 16'h0, 16'h2, 16'h0, 16'h0, 16'h3, 16'h4});
        send_address({16'h1, 16'h0, 16'h0, 16'h2, 16'h0, 16'h0, 16'h0, 16'h3});
        send_address({16'h1, 16'h2, 16'h0, 16'h0, 16'h0, 16'h3, 16'h0, 16'h0});
        send_address({16'h1, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6, 16'h0, 16'h0});
        send_address({16'h0, 16'h0, 16'h1, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6});
        send_address({16'h0, 16'h1, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6, 16'h7});
        send_address({16'h1, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6, 16'h7, 16'h0});
        send_address({16'h1000, 16'h0fff, 16'h00f0, 16'h000a,
                      16'habcd, 16'h0010, 16'h0100, 16'h8000});
        send_address({16'h2001, 16'h0db8, 16'h0, 16'h0, 16'h8, 16'h800, 16'h200c, 16'h417a});
        send_address({16'h0, 16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0, 16'h0});
        send_address({16'hfedc, 16'hba98, 16'h7654, 16'h3210, 16'h0, 16'h0, 16'h0, 16'h0});
        wait_text_done();
    endtask

    task automatic test_directed_plain();
        write_bracket(1'b0);
        send_address({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
        send_address({16'h1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
        send_address({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1});
        send_address({16'h1234, 16'h5678, 16'h9abc, 16'hdef0,
                      16'h1111, 16'h2222, 16'h3333, 16'h4444});
        send_address({16'h0, 16'h1, 16'h0, 16'h1, 16'h0, 16'h1, 16'h0, 16'h1});
        send_address({16'h1, 16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0, 16'h0});
        wait_text_done();
        write_bracket(1'b1);
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 6; phase++)
        begin
            write_bracket((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
            for (n = 0; n < 50; n++)
                send_address(random_address());
            wait_text_done();
        end
    endtask

    task automatic test_steady_flow();
        int n;
        steady_flow = 1'b1;
        for (n = 0; n < 40; n++)
            send_address(random_address());
        wait_text_done();
        steady_flow = 1'b0;
    endtask

    task automatic test_output_backpressure();
        int n;
        hold_cycles = 400;
        for (n = 0; n < 12; n++)
            send_address(random_address());
        wait_text_done();
    endtask

    task automatic test_sender_pause();
        int n;
        for (n = 0; n < 6; n++)
            send_address(random_address());
        wait_text_done();
        for (n = 0; n < 6; n++)
            send_address(random_address());
        wait_text_done();
    endtask

    // receiver: random stall before each word, long hold on request
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
                stall = hold_cycles;
            else
                stall = steady_flow ? 0 : $urandom_range(0, 9);
            hold_cycles = 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_text.size() == 0)
            begin
                $display("%0t: unexpected word char_code=%h last_char=%b",
                         $time, char_code, last_char);
                mismatches++;
            end
            else
            begin
                head_char = pending_text.pop_front();
                if (char_code !== head_char.code)
                begin
                    $display("%0t: char_code expected %h actual %h",
                             $time, head_char.code, char_code);
                    mismatches++;
                end
                if (last_char !== head_char.last)
                begin
                    $display("%0t: last_char expected %b actual %b",
                             $time, head_char.last, last_char);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int waited;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_bracketed();
        test_directed_plain();
        test_random_traffic();
        test_steady_flow();
        test_output_backpressure();
        test_sender_pause();

        in_valid <= 1'b0;
        waited = 0;
        while (pending_text.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending_text.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, pending_text.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/core/ipv6ts_pkg.sv
rtl/core/ipv6ts_lane.sv
rtl/core/ipv6ts_merge.sv
rtl/core/ipv6_text_serializer.sv
rtl/core/ipv6ts_checker.sv
test/ipv6_text_serializer_test.sv
